[hdl/dcf_pkg.sv]
// Shared constants, types and helper functions of the time code decoder.
package dcf_pkg;

    localparam int unsigned FRAME_LEN  = 59;
    localparam int unsigned COUNT_W    = 6;
    localparam int unsigned WINDOW_LEN = 10;
    localparam int unsigned SUM_W      = 4;
    localparam int unsigned LOW_LIMIT  = 3;
    localparam int unsigned HIGH_LIMIT = 7;
    localparam int unsigned NUM_REGS   = 8;
    localparam int unsigned REG_IDX_W  = 3;
    localparam int unsigned MS_W       = 16;
    localparam int unsigned HOUR_MAX   = 23;
    localparam int unsigned MINUTE_MAX = 59;

    localparam logic [2:0] EV_NONE    = 3'd0;
    localparam logic [2:0] EV_SECOND  = 3'd1;
    localparam logic [2:0] EV_MINUTE  = 3'd2;
    localparam logic [2:0] EV_ZERO    = 3'd3;
    localparam logic [2:0] EV_ONE     = 3'd4;
    localparam logic [2:0] EV_INVALID = 3'd5;

    localparam logic [REG_IDX_W-1:0] REG_SECOND_MIN = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_SECOND_MAX = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_MINUTE_MIN = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_MINUTE_MAX = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_ZERO_MIN   = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_ZERO_MAX   = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_ONE_MIN    = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_ONE_MAX    = 3'd7;

    typedef logic [MS_W-1:0] t_ms;

    localparam t_ms CFG_RESET [NUM_REGS] = '{
        16'd900, 16'd1100, 16'd1900, 16'd2100, 16'd80, 16'd130, 16'd170, 16'd230
    };

    typedef struct packed {
        logic [5:0] hour;
        logic [6:0] minute;
        logic [5:0] day;
        logic [2:0] weekday;
        logic [4:0] month;
        logic [7:0] year;
    } t_fields;

    localparam t_fields FIELDS_RESET = '{
        hour: 6'd0, minute: 7'd0, day: 6'd17, weekday: 3'd1, month: 5'd1, year: 8'd23
    };

    typedef struct packed {
        logic changed;
        logic level;
    } t_level_info;

    typedef struct packed {
        logic    done;
        logic    ok;
        t_fields fields;
    } t_frame_result;

    // Weights 1, 2, 4, 8 on the low nibble and 10, 20, 40, 80 on the high nibble.
    function automatic logic [7:0] bcd_value(input logic [7:0] bits);
        logic [7:0] tens;
        tens = 8'(bits[7:4]);
        return {4'd0, bits[3:0]} + 8'(tens * 8'd10);
    endfunction

    function automatic logic in_window(input t_ms t, input t_ms lo, input t_ms hi);
        return (t >= lo) && (t <= hi);
    endfunction

endpackage

[hdl/dcf_if.sv]
// Request channel interfaces of the time code decoder: sample input, result output, config.
interface dcf_in_if;
    logic                     valid;
    logic                     ready;
    logic                     raw_level;
    logic [dcf_pkg::MS_W-1:0] elapsed_ms;

    modport source (output valid, output raw_level, output elapsed_ms, input ready);
    modport sink (input valid, input raw_level, input elapsed_ms, output ready);
endinterface

interface dcf_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] event_code;
    logic       clean_level;
    logic       decode_done;
    logic       decode_ok;
    logic [5:0] hour_value;
    logic [6:0] minute_value;
    logic [5:0] day_value;
    logic [2:0] weekday_value;
    logic [4:0] month_value;
    logic [7:0] year_value;

    modport source (
        output valid, output event_code, output clean_level, output decode_done,
        output decode_ok, output hour_value, output minute_value, output day_value,
        output weekday_value, output month_value, output year_value, input ready
    );
    modport sink (
        input valid, input event_code, input clean_level, input decode_done,
        input decode_ok, input hour_value, input minute_value, input day_value,
        input weekday_value, input month_value, input year_value, output ready
    );
endinterface

interface dcf_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [dcf_pkg::REG_IDX_W-1:0] index;
    logic [dcf_pkg::MS_W-1:0]      data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

[hdl/dcf77_time_signal_decoder.sv]
// Top level of the time code decoder: input register, edge timing, result register.
//
// Usage:
//   i_in carries one 10 ms sample request: raw_level and elapsed_ms, the time
//   since the caller's reference edge. o_out returns one result per sample:
//   event_code, clean_level, decode_done, decode_ok and the held date fields.
//   i_cfg, always ready, writes the eight 16-bit timing window registers by index;
//   the user must write it only while no sample is in flight, unchecked by the block.
// Datapath and throughput:
//   An accepted sample is held in the input register, processed by combinational
//   logic and shown on o_out from the result register. One sample per cycle is
//   sustained while o_out is ready; the window update, edge timing and frame
//   decode all sit in that combinational logic between the input register and
//   the result register.
// Reset:
//   i_rst_n clears the valid bits of both registers, sets the clean level high,
//   stops frame collection, restores default windows and the default date fields.
// Stall:
//   While o_out is held off, the result stays put and one more sample waits
//   in the input register; after that i_in.ready drops until o_out moves.
module dcf77_time_signal_decoder (
    input  logic      i_clk,
    input  logic      i_rst_n,
    dcf_in_if.sink    i_in,
    dcf_out_if.source o_out,
    dcf_cfg_if.sink   i_cfg
);

    dcf_pkg::t_ms          r_cfg [dcf_pkg::NUM_REGS];
    logic                  r_in_valid;
    logic                  r_raw;
    dcf_pkg::t_ms          r_ms;
    logic                  r_out_valid;
    logic [2:0]            r_out_event;
    logic                  r_out_level;
    dcf_pkg::t_frame_result r_out_frame;

    logic                  fire;
    logic                  in_take;
    logic [2:0]            event_code;
    dcf_pkg::t_level_info  level_info;
    dcf_pkg::t_frame_result frame_result;

    assign fire      = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || fire;
    assign in_take   = i_in.valid && i_in.ready;
    assign i_cfg.ready = 1'b1;

    dcf_debounce u_debounce (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_raw   (r_raw),
        .o_info  (level_info)
    );

    always_comb begin
        event_code = dcf_pkg::EV_NONE;
        if (level_info.changed) begin
            if (!level_info.level) begin
                if (dcf_pkg::in_window(r_ms, r_cfg[dcf_pkg::REG_SECOND_MIN],
                        r_cfg[dcf_pkg::REG_SECOND_MAX])) begin
                    event_code = dcf_pkg::EV_SECOND;
                end else if (dcf_pkg::in_window(r_ms, r_cfg[dcf_pkg::REG_MINUTE_MIN],
                        r_cfg[dcf_pkg::REG_MINUTE_MAX])) begin
                    event_code = dcf_pkg::EV_MINUTE;
                end else begin
                    event_code = dcf_pkg::EV_INVALID;
                end
            end else begin
                if (dcf_pkg::in_window(r_ms, r_cfg[dcf_pkg::REG_ZERO_MIN],
                        r_cfg[dcf_pkg::REG_ZERO_MAX])) begin
                    event_code = dcf_pkg::EV_ZERO;
                end else if (dcf_pkg::in_window(r_ms, r_cfg[dcf_pkg::REG_ONE_MIN],
                        r_cfg[dcf_pkg::REG_ONE_MAX])) begin
                    event_code = dcf_pkg::EV_ONE;
                end else begin
                    event_code = dcf_pkg::EV_INVALID;
                end
            end
        end
    end

    dcf_frame u_frame (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (fire),
        .i_event  (event_code),
        .o_result (frame_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= dcf_pkg::CFG_RESET;
        end else if (i_cfg.valid) begin
            r_cfg[i_cfg.index] <= i_cfg.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (fire) begin
                r_in_valid <= 1'b0;
            end
            if (fire) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_raw <= i_in.raw_level;
            r_ms  <= i_in.elapsed_ms;
        end
        if (fire) begin
            r_out_event <= event_code;
            r_out_level <= level_info.level;
            r_out_frame <= frame_result;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.event_code    = r_out_event;
    assign o_out.clean_level   = r_out_level;
    assign o_out.decode_done   = r_out_frame.done;
    assign o_out.decode_ok     = r_out_frame.ok;
    assign o_out.hour_value    = r_out_frame.fields.hour;
    assign o_out.minute_value  = r_out_frame.fields.minute;
    assign o_out.day_value     = r_out_frame.fields.day;
    assign o_out.weekday_value = r_out_frame.fields.weekday;
    assign o_out.month_value   = r_out_frame.fields.month;
    assign o_out.year_value    = r_out_frame.fields.year;

`ifndef NO_ASSERTIONS
    a_ok_needs_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_frame.ok |-> r_out_frame.done)
        else $error("decode_ok raised without a decode");
`endif

endmodule

[hdl/dcf_debounce.sv]
// Ten-sample majority window with hysteresis that yields the clean line level.
module dcf_debounce (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_fire,
    input  logic                 i_raw,
    output dcf_pkg::t_level_info o_info
);

    // The nine older samples; the tenth is the sample being processed.
    logic [dcf_pkg::WINDOW_LEN-2:0] r_window;
    logic [dcf_pkg::WINDOW_LEN-2:0] n_window;
    logic                           r_level;
    logic                           n_level;
    logic [dcf_pkg::SUM_W-1:0]      sum;

    always_comb begin
        sum = dcf_pkg::SUM_W'($countones({r_window, i_raw}));
        if (sum <= dcf_pkg::SUM_W'(dcf_pkg::LOW_LIMIT)) begin
            n_level = 1'b0;
        end else if (sum >= dcf_pkg::SUM_W'(dcf_pkg::HIGH_LIMIT)) begin
            n_level = 1'b1;
        end else begin
            n_level = r_level;
        end
        n_window       = {r_window[dcf_pkg::WINDOW_LEN-3:0], i_raw};
        o_info.changed = (n_level != r_level);
        o_info.level   = n_level;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window <= '0;
            r_level  <= 1'b1;
        end else if (i_fire) begin
            r_window <= n_window;
            r_level  <= n_level;
        end
    end

`ifndef NO_ASSERTIONS
    a_edge_flips_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && o_info.changed |=> r_level != $past(r_level))
        else $error("clean level did not change on a detected edge");
`endif

endmodule

[hdl/dcf_frame.sv]
// Frame bit collection, BCD decode and frame checks.
module dcf_frame (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_fire,
    input  logic [2:0]             i_event,
    output dcf_pkg::t_frame_result o_result
);

    logic                             r_coll;
    logic                             n_coll;
    logic [dcf_pkg::COUNT_W-1:0]      r_count;
    logic [dcf_pkg::COUNT_W-1:0]      n_count;
    // Bits shift in at the top, so after a full frame bit k sits at position k.
    logic [dcf_pkg::FRAME_LEN-1:0]    r_frame;
    logic [dcf_pkg::FRAME_LEN-1:0]    n_frame;
    dcf_pkg::t_fields                 r_fields;
    dcf_pkg::t_fields                 n_fields;
    dcf_pkg::t_fields                 dec_fields;
    logic                             dec_ok;
    logic                             coll_now;
    logic                             done;
    logic [7:0]                       minute_full;
    logic [7:0]                       hour_full;
    logic [7:0]                       day_full;
    logic [7:0]                       month_full;
    logic [7:0]                       year_full;

    always_comb begin
        minute_full = dcf_pkg::bcd_value({1'b0, r_frame[27:21]});
        hour_full   = dcf_pkg::bcd_value({2'b0, r_frame[34:29]});
        day_full    = dcf_pkg::bcd_value({2'b0, r_frame[41:36]});
        month_full  = dcf_pkg::bcd_value({3'b0, r_frame[49:45]});
        year_full   = dcf_pkg::bcd_value(r_frame[57:50]);

        dec_fields.minute  = minute_full[6:0];
        dec_fields.hour    = hour_full[5:0];
        dec_fields.day     = day_full[5:0];
        dec_fields.weekday = r_frame[44:42];
        dec_fields.month   = month_full[4:0];
        dec_fields.year    = year_full;

        dec_ok = !(^r_frame[28:21]) && !(^r_frame[35:29]) && !(^r_frame[58:36])
            && (hour_full <= 8'(dcf_pkg::HOUR_MAX))
            && (minute_full <= 8'(dcf_pkg::MINUTE_MAX))
            && r_frame[20];
    end

    always_comb begin
        coll_now = r_coll || (i_event == dcf_pkg::EV_MINUTE);
        n_coll   = coll_now;
        n_count  = r_count;
        n_frame  = r_frame;
        n_fields = r_fields;
        done     = 1'b0;
        if (coll_now) begin
            if (r_count < dcf_pkg::COUNT_W'(dcf_pkg::FRAME_LEN)) begin
                if (i_event == dcf_pkg::EV_ZERO || i_event == dcf_pkg::EV_ONE) begin
                    n_frame = {(i_event == dcf_pkg::EV_ONE), r_frame[dcf_pkg::FRAME_LEN-1:1]};
                    n_count = r_count + 1'b1;
                end else if (i_event == dcf_pkg::EV_INVALID) begin
                    n_coll  = 1'b0;
                    n_count = '0;
                end
            end else begin
                // Full frame: the event of this tick is not collected.
                n_fields = dec_fields;
                done     = 1'b1;
                n_count  = '0;
            end
        end
        o_result.done   = done;
        o_result.ok     = done && dec_ok;
        o_result.fields = n_fields;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coll   <= 1'b0;
            r_count  <= '0;
            r_fields <= dcf_pkg::FIELDS_RESET;
        end else if (i_fire) begin
            r_coll   <= n_coll;
            r_count  <= n_count;
            r_fields <= n_fields;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_fire) begin
            r_frame <= n_frame;
        end
    end

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= dcf_pkg::COUNT_W'(dcf_pkg::FRAME_LEN))
        else $error("bit count ran past the frame length");
    a_done_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && o_result.done |=> r_count == '0 && r_coll)
        else $error("decode did not restart collection");
    a_count_needs_coll: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_coll |-> r_count == '0)
        else $error("bits counted while not collecting");
`endif

endmodule

[tb/sv/dcf77_time_signal_decoder_tb.sv]
// Self-checking testbench of the time code decoder: sample stimulus, bit-exact predictor, checks.
module dcf77_time_signal_decoder_tb;

    localparam int unsigned CYCLE_LIMIT = 200000;

    localparam int FRAME_CLEAN   = 0;
    localparam int FRAME_FLIPPED = 1;
    localparam int FRAME_RANDOM  = 2;

    typedef struct packed {
        logic         raw;
        dcf_pkg::t_ms ms;
    } t_line_sample;

    typedef struct packed {
        logic [2:0]       ev;
        logic             lvl;
        logic             done;
        logic             ok;
        dcf_pkg::t_fields fields;
    } t_line_result;

    logic i_clk;
    logic i_rst_n;

    dcf_in_if  in_bus ();
    dcf_out_if out_bus ();
    dcf_cfg_if cfg_bus ();

    dcf77_time_signal_decoder u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_bus),
        .o_out   (out_bus),
        .i_cfg   (cfg_bus)
    );

    // Predictor state.
    dcf_pkg::t_ms                  win_cfg [dcf_pkg::NUM_REGS];
    logic                          line_hist [dcf_pkg::WINDOW_LEN];
    int unsigned                   hist_pos;
    logic                          clean_lvl;
    logic                          in_frame;
    int unsigned                   bits_taken;
    logic [dcf_pkg::FRAME_LEN-1:0] frame_bits;
    dcf_pkg::t_fields              held_fields;

    // Stimulus and scoreboard.
    t_line_sample                  sample_q [$];
    t_line_result                  sample_results [$];
    t_line_sample                  next_sample;
    t_line_result                  due;
    logic [dcf_pkg::FRAME_LEN-1:0] frame_plan;
    int unsigned                   send_gap_pct;
    int unsigned                   recv_gap_pct;
    int unsigned                   mismatches;
    int unsigned                   cycles;

    always #2 i_clk = ~i_clk;

    function automatic logic [2:0] classify_edge(input logic falling, input dcf_pkg::t_ms ms);
        if (falling) begin
            if (ms >= win_cfg[dcf_pkg::REG_SECOND_MIN] && ms <= win_cfg[dcf_pkg::REG_SECOND_MAX])
                return dcf_pkg::EV_SECOND;
            if (ms >= win_cfg[dcf_pkg::REG_MINUTE_MIN] && ms <= win_cfg[dcf_pkg::REG_MINUTE_MAX])
                return dcf_pkg::EV_MINUTE;
        end else begin
            if (ms >= win_cfg[dcf_pkg::REG_ZERO_MIN] && ms <= win_cfg[dcf_pkg::REG_ZERO_MAX])
                return dcf_pkg::EV_ZERO;
            if (ms >= win_cfg[dcf_pkg::REG_ONE_MIN] && ms <= win_cfg[dcf_pkg::REG_ONE_MAX])
                return dcf_pkg::EV_ONE;
        end
        return dcf_pkg::EV_INVALID;
    endfunction

    function automatic int unsigned bcd_sum(input logic [dcf_pkg::FRAME_LEN-1:0] v,
                                            input int first, input int n);
        int unsigned acc;
        int          i;
        acc = 0;
        for (i = 0; i < n; i++) begin
            if (v[first + i]) acc += (i < 4) ? (1 << i) : 10 * (1 << (i - 4));
        end
        return acc;
    endfunction

    function automatic logic xor_span(input logic [dcf_pkg::FRAME_LEN-1:0] v, input int first,
                                      input int last);
        logic p;
        int   i;
        p = 1'b0;
        for (i = first; i <= last; i++) p ^= v[i];
        return p;
    endfunction

    // Advances the predictor by one line sample and returns the result it must produce.
    function automatic t_line_result time_code_step(input logic raw, input dcf_pkg::t_ms ms);
        t_line_result r;
        int unsigned  ones;
        logic         lvl;
        logic [2:0]   ev;
        int           k;
        ev = dcf_pkg::EV_NONE;
        r.done = 1'b0;
        r.ok = 1'b0;
        line_hist[hist_pos] = raw;
        hist_pos = (hist_pos == dcf_pkg::WINDOW_LEN - 1) ? 0 : hist_pos + 1;
        ones = 0;
        for (k = 0; k < dcf_pkg::WINDOW_LEN; k++) ones += line_hist[k];
        if (ones <= dcf_pkg::LOW_LIMIT || ones >= dcf_pkg::HIGH_LIMIT) begin
            lvl = (ones >= dcf_pkg::HIGH_LIMIT);
            if (lvl != clean_lvl) begin
                clean_lvl = lvl;
                ev = classify_edge(!lvl, ms);
                if (ev == dcf_pkg::EV_MINUTE) in_frame = 1'b1;
            end
        end
        if (in_frame) begin
            if (bits_taken < dcf_pkg::FRAME_LEN) begin
                if (ev == dcf_pkg::EV_ZERO || ev == dcf_pkg::EV_ONE) begin
                    frame_bits[bits_taken] = (ev == dcf_pkg::EV_ONE);
                    bits_taken++;
                end else if (ev == dcf_pkg::EV_INVALID) begin
                    in_frame = 1'b0;
                    bits_taken = 0;
                end
            end else begin
                // The decode tick: fields are updated even when a check fails.
                held_fields.minute  = 7'(bcd_sum(frame_bits, 21, 7));
                held_fields.hour    = 6'(bcd_sum(frame_bits, 29, 6));
                held_fields.day     = 6'(bcd_sum(frame_bits, 36, 6));
                held_fields.weekday = 3'(bcd_sum(frame_bits, 42, 3));
                held_fields.month   = 5'(bcd_sum(frame_bits, 45, 5));
                held_fields.year    = 8'(bcd_sum(frame_bits, 50, 8));
                r.ok = !xor_span(frame_bits, 21, 28) && !xor_span(frame_bits, 29, 35)
                    && !xor_span(frame_bits, 36, 58) && held_fields.hour <= dcf_pkg::HOUR_MAX
                    && held_fields.minute <= dcf_pkg::MINUTE_MAX && frame_bits[20];
                r.done = 1'b1;
                bits_taken = 0;
            end
        end
        r.ev = ev;
        r.lvl = clean_lvl;
        r.fields = held_fields;
        return r;
    endfunction

    // Tries to pick an elapsed time that the current windows classify as the wanted event.
    function automatic dcf_pkg::t_ms choose_ms(input logic falling, input logic [2:0] want);
        dcf_pkg::t_ms lo;
        dcf_pkg::t_ms hi;
        dcf_pkg::t_ms v;
        int           k;
        case (want)
            dcf_pkg::EV_SECOND: begin
                lo = win_cfg[dcf_pkg::REG_SECOND_MIN];
                hi = win_cfg[dcf_pkg::REG_SECOND_MAX];
            end
            dcf_pkg::EV_MINUTE: begin
                lo = win_cfg[dcf_pkg::REG_MINUTE_MIN];
                hi = win_cfg[dcf_pkg::REG_MINUTE_MAX];
            end
            dcf_pkg::EV_ZERO: begin
                lo = win_cfg[dcf_pkg::REG_ZERO_MIN];
                hi = win_cfg[dcf_pkg::REG_ZERO_MAX];
            end
            dcf_pkg::EV_ONE: begin
                lo = win_cfg[dcf_pkg::REG_ONE_MIN];
                hi = win_cfg[dcf_pkg::REG_ONE_MAX];
            end
            default: begin
                lo = '1;
                hi = '0;
            end
        endcase
        v = '0;
        for (k = 0; k < 32; k++) begin
            if (k >= 16 || lo > hi) v = dcf_pkg::t_ms'($urandom);
            else v = dcf_pkg::t_ms'($urandom_range(hi, lo));
            if (classify_edge(falling, v) == want) return v;
        end
        return v;
    endfunction

    function automatic void push_sample(input logic raw, input dcf_pkg::t_ms ms);
        t_line_sample s;
        s.raw = raw;
        s.ms = ms;
        sample_q.push_back(s);
    endfunction

    // A run of equal samples; only the last one can carry the level change.
    function automatic void push_run(input logic lvl, input int len, input dcf_pkg::t_ms edge_ms);
        int k;
        for (k = 0; k < len - 1; k++) push_sample(lvl, dcf_pkg::t_ms'($urandom));
        push_sample(lvl, edge_ms);
    endfunction

    function automatic void put_bcd(input int first, input int n, input int unsigned value);
        int unsigned units;
        int unsigned tens;
        int          i;
        units = value % 10;
        tens = value / 10;
        for (i = 0; i < n; i++) begin
            frame_plan[first + i] = (i < 4) ? ((units >> i) & 1) : ((tens >> (i - 4)) & 1);
        end
    endfunction

    // A whole minute of line activity: stop any collection, minute mark, then the bits.
    // A frame cut short ends with an invalid pulse at bit cut_at.
    function automatic void push_frame(input int flaw, input int cut_at);
        int b;
        frame_plan = '0;
        for (b = 0; b < dcf_pkg::FRAME_LEN; b++) frame_plan[b] = $urandom_range(1);
        if (flaw != FRAME_RANDOM) begin
            put_bcd(21, 7, $urandom_range(59));
            put_bcd(29, 6, $urandom_range(23));
            put_bcd(36, 6, $urandom_range(31, 1));
            put_bcd(42, 3, $urandom_range(7, 1));
            put_bcd(45, 5, $urandom_range(12, 1));
            put_bcd(50, 8, $urandom_range(99));
            frame_plan[20] = 1'b1;
            frame_plan[28] = xor_span(frame_plan, 21, 27);
            frame_plan[35] = xor_span(frame_plan, 29, 34);
            frame_plan[58] = xor_span(frame_plan, 36, 57);
            if (flaw == FRAME_FLIPPED) begin
                b = $urandom_range(dcf_pkg::FRAME_LEN - 1, 20);
                frame_plan[b] = !frame_plan[b];
            end
        end
        push_run(1'b1, 10, dcf_pkg::t_ms'($urandom));
        push_run(1'b0, 7, choose_ms(1'b1, dcf_pkg::EV_INVALID));
        push_run(1'b1, 7, dcf_pkg::t_ms'($urandom));
        push_run(1'b0, 7, choose_ms(1'b1, dcf_pkg::EV_MINUTE));
        for (b = 0; b < dcf_pkg::FRAME_LEN; b++) begin
            if (b == cut_at) begin
                push_run(1'b1, 7, choose_ms(1'b0, dcf_pkg::EV_INVALID));
                return;
            end
            push_run(1'b1, 7,
                     choose_ms(1'b0, frame_plan[b] ? dcf_pkg::EV_ONE : dcf_pkg::EV_ZERO));
            push_run(1'b0, 7, choose_ms(1'b1, (b == dcf_pkg::FRAME_LEN - 1) ?
                                              dcf_pkg::EV_MINUTE : dcf_pkg::EV_SECOND));
        end
    endfunction

    // Random runs of random length, most times aimed at one of the windows.
    function automatic void push_noise(input int n);
        int         left;
        int         len;
        int         k;
        logic       lvl;
        logic [2:0] aim;
        left = n;
        while (left > 0) begin
            lvl = $urandom_range(1);
            len = $urandom_range(12, 1);
            for (k = 0; k < len && left > 0; k++) begin
                if (lvl) aim = $urandom_range(1) ? dcf_pkg::EV_ZERO : dcf_pkg::EV_ONE;
                else aim = $urandom_range(1) ? dcf_pkg::EV_SECOND : dcf_pkg::EV_MINUTE;
                push_sample(lvl, ($urandom_range(3) == 0) ? dcf_pkg::t_ms'($urandom)
                                                          : choose_ms(!lvl, aim));
                left--;
            end
        end
    endfunction

    task automatic drain_results();
        while (sample_q.size() != 0 || in_bus.valid || sample_results.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    task automatic write_reg(input logic [dcf_pkg::REG_IDX_W-1:0] idx,
                             input dcf_pkg::t_ms value);
        @(posedge i_clk);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= value;
        do @(posedge i_clk); while (!(cfg_bus.valid && cfg_bus.ready));
        win_cfg[idx] = value;
        cfg_bus.valid <= 1'b0;
    endtask

    task automatic load_windows(input dcf_pkg::t_ms s_lo, input dcf_pkg::t_ms s_hi,
                                input dcf_pkg::t_ms m_lo, input dcf_pkg::t_ms m_hi,
                                input dcf_pkg::t_ms z_lo, input dcf_pkg::t_ms z_hi,
                                input dcf_pkg::t_ms o_lo, input dcf_pkg::t_ms o_hi);
        write_reg(dcf_pkg::REG_SECOND_MIN, s_lo);
        write_reg(dcf_pkg::REG_SECOND_MAX, s_hi);
        write_reg(dcf_pkg::REG_MINUTE_MIN, m_lo);
        write_reg(dcf_pkg::REG_MINUTE_MAX, m_hi);
        write_reg(dcf_pkg::REG_ZERO_MIN, z_lo);
        write_reg(dcf_pkg::REG_ZERO_MAX, z_hi);
        write_reg(dcf_pkg::REG_ONE_MIN, o_lo);
        write_reg(dcf_pkg::REG_ONE_MAX, o_hi);
        @(negedge i_clk);
    endtask

    task automatic check_field(input string what, input logic [7:0] want, input logic [7:0] got);
        if (got !== want) begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
        end
    endtask

    // Sample driver.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_bus.valid <= 1'b0;
        end else begin
            if (in_bus.valid && in_bus.ready) begin
                sample_results.push_back(time_code_step(in_bus.raw_level, in_bus.elapsed_ms));
            end
            if (!in_bus.valid || in_bus.ready) begin
                if (sample_q.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
                    next_sample = sample_q.pop_front();
                    in_bus.valid      <= 1'b1;
                    in_bus.raw_level  <= next_sample.raw;
                    in_bus.elapsed_ms <= next_sample.ms;
                end else begin
                    in_bus.valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_bus.ready <= 1'b0;
        end else begin
            if (out_bus.valid && out_bus.ready) begin
                if (sample_results.size() == 0) begin
                    mismatches++;
                    $display("%0t: result with no request pending, expected none, actual event %0d",
                             $time, out_bus.event_code);
                end else begin
                    due = sample_results.pop_front();
                    check_field("event_code", 8'(due.ev), 8'(out_bus.event_code));
                    check_field("clean_level", 8'(due.lvl), 8'(out_bus.clean_level));
                    check_field("decode_done", 8'(due.done), 8'(out_bus.decode_done));
                    check_field("decode_ok", 8'(due.ok), 8'(out_bus.decode_ok));
                    check_field("hour_value", 8'(due.fields.hour), 8'(out_bus.hour_value));
                    check_field("minute_value", 8'(due.fields.minute), 8'(out_bus.minute_value));
                    check_field("day_value", 8'(due.fields.day), 8'(out_bus.day_value));
                    check_field("weekday_value", 8'(due.fields.weekday),
                                8'(out_bus.weekday_value));
                    check_field("month_value", 8'(due.fields.month), 8'(out_bus.month_value));
                    check_field("year_value", 8'(due.fields.year), 8'(out_bus.year_value));
                end
            end
            out_bus.ready <= ($urandom_range(99) >= recv_gap_pct);
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    initial begin
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        in_bus.valid = 1'b0;
        in_bus.raw_level = 1'b0;
        in_bus.elapsed_ms = '0;
        out_bus.ready = 1'b0;
        cfg_bus.valid = 1'b0;
        cfg_bus.index = dcf_pkg::REG_SECOND_MIN;
        cfg_bus.data = '0;
        foreach (win_cfg[r]) win_cfg[r] = dcf_pkg::CFG_RESET[r];
        foreach (line_hist[k]) line_hist[k] = 1'b0;
        hist_pos = 0;
        clean_lvl = 1'b1;
        in_frame = 1'b0;
        bits_taken = 0;
        frame_bits = '0;
        held_fields = dcf_pkg::FIELDS_RESET;
        mismatches = 0;
        cycles = 0;
        send_gap_pct = 27;
        recv_gap_pct = 88;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Out of reset the clean level is high while the window is all zeros, so the
        // very first sample is a falling edge. Then a zero bit outside a frame, a minute
        // mark and a one bit, with both extremes of the elapsed time.
        push_sample(1'b0, 16'hFFFF);
        push_run(1'b1, 7, 16'd100);
        push_run(1'b0, 7, 16'd2000);
        push_run(1'b1, 7, 16'd200);
        push_sample(1'b1, 16'h0000);
        push_sample(1'b1, 16'hFFFF);
        push_sample(1'b0, 16'h0000);
        push_frame(FRAME_CLEAN, -1);
        drain_results();

        // Wide, adjacent windows; a frame that breaks off with an invalid pulse, then noise.
        send_gap_pct = 88;
        recv_gap_pct = 27;
        load_windows(16'd0, 16'd1000, 16'd1001, 16'd3000, 16'd10, 16'd150, 16'd151, 16'd300);
        push_frame($urandom_range(FRAME_RANDOM), $urandom_range(2, 1));
        push_noise(16);
        drain_results();

        // Second window inverted, so every falling edge is a minute mark and every
        // rising edge is a bit: collection never stops.
        send_gap_pct = 0;
        recv_gap_pct = 0;
        load_windows(16'hFFFF, 16'd0, 16'd0, 16'hFFFF, 16'd0, 16'd0, 16'd1, 16'hFFFF);
        push_noise(24);
        drain_results();

        repeat (10) @(posedge i_clk);
        if (mismatches == 0 && sample_results.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

[sim.f]
hdl/dcf_pkg.sv
hdl/dcf_if.sv
hdl/dcf_debounce.sv
hdl/dcf_frame.sv
hdl/dcf77_time_signal_decoder.sv
tb/sv/dcf77_time_signal_decoder_tb.sv
